// ===== rtl/core/tkl_pkg.sv =====
`default_nettype none

package tkl_pkg;

    localparam int LEN_W = 10;
    localparam int TAG_W = 16;
    localparam int CAP_W = 5;
    localparam int CMD_W = 2;
    localparam int LIMIT_W = 17;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DUMP   = 2'd1,
        CMD_CLEAR  = 2'd2
    } command_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FULL_CHK,
        ST_INS_RD,
        ST_INS_CHK,
        ST_DUMP_RD,
        ST_DUMP_LD
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
    } entry_t;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/top_k_by_length_tracker_unit.sv =====
`default_nettype none

// channel  | direction | handshake          | payload
// s_       | in        | s_tvalid/s_tready  | tdata: command, item_length, item_tag
// m_       | out       | m_tvalid/m_tready  | tdata: entry_length, entry_tag; tuser; tlast
// cfg_     | in        | cfg_valid/cfg_ready| cfg_data: capacity
//
// insert: entries no longer than the new one shift down one slot each, from the end
//   up, and the new entry lands below any longer one; a full store first checks its last
//   entry and drops the item unless it is longer; the entry memory has a single read port
// dump: a memory read, then an output register load, per entry
// clear, unused commands and an ignored insert are handled in idle
// reset clears the entry count and the output valid flag; memory contents are not cleared
// a full output register stalls a dump until m_tready frees it

module top_k_by_length_tracker_unit
    import tkl_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int MAX_LINE    = 1024
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [31:0]      s_tdata,   // command, item_length, item_tag
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [31:0]           m_tdata,   // entry_length, entry_tag
    output logic                  m_tuser,   // entry_valid
    output logic                  m_tlast,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data
);

    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [LIMIT_W-1:0] LEN_LIMIT = LIMIT_W'(MAX_LINE - 1);
    localparam logic [CMPW-1:0]    MAX_EXT   = CMPW'(MAX_ENTRIES);

    entry_t mem [MAX_ENTRIES];

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [CAP_W-1:0] capacity_reg;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    entry_t           wr_data;

    logic             out_load;
    logic             out_free;
    result_t          out_result;

    command_t         in_cmd;
    logic [LEN_W-1:0] in_len;
    logic [TAG_W-1:0] in_tag;
    logic [LEN_W-1:0] in_len_sat;
    logic [CMPW-1:0]  cap_ext;
    logic [CMPW-1:0]  cap_eff;
    logic             has_room;
    logic [CW-1:0]    count_dec;
    logic             dump_last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_W'(16);
        end else if (cfg_valid) begin
            capacity_reg <= cfg_data;
        end
    end

    assign in_cmd     = command_t'(s_tdata[1:0]);
    assign in_len     = s_tdata[11:2];
    assign in_tag     = s_tdata[27:12];
    assign in_len_sat = ({(LIMIT_W - LEN_W)'(0), in_len} > LEN_LIMIT)
                        ? LEN_W'(LEN_LIMIT) : in_len;

    assign cap_ext   = CMPW'(capacity_reg);
    assign cap_eff   = (cap_ext > MAX_EXT) ? MAX_EXT : cap_ext;
    assign has_room  = CMPW'(count_reg) < cap_eff;
    assign count_dec = count_reg - CW'(1);
    assign dump_last = (CW'(idx_reg) + CW'(1)) == count_reg;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        tag_next   = tag_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = '{tag: tag_reg, len: len_reg};
        out_load   = 1'b0;
        out_result = '{valid: 1'b1, len: rd_data.len, tag: rd_data.tag, last: dump_last};
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    len_next = in_len_sat;
                    tag_next = in_tag;
                    case (in_cmd)
                        CMD_INSERT: begin
                            if (has_room) begin
                                idx_next   = AW'(count_reg);
                                count_next = count_reg + CW'(1);
                                state_next = ST_INS_RD;
                            end else if (count_reg != '0) begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(count_dec);
                                state_next = ST_FULL_CHK;
                            end
                        end
                        CMD_DUMP: begin
                            idx_next   = '0;
                            state_next = ST_DUMP_RD;
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FULL_CHK: begin
                if (len_reg > rd_data.len) begin
                    idx_next   = AW'(count_dec);
                    state_next = ST_INS_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_INS_RD: begin
                if (idx_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg - AW'(1);
                    state_next = ST_INS_CHK;
                end
            end
            ST_INS_CHK: begin
                wr_en = 1'b1;
                if (rd_data.len <= len_reg) begin
                    wr_data    = rd_data;
                    idx_next   = idx_reg - AW'(1);
                    state_next = ST_INS_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP_RD: begin
                if (out_free) begin
                    if (count_reg == '0) begin
                        out_load   = 1'b1;
                        out_result = '{valid: 1'b0, len: '0, tag: '0, last: 1'b1};
                        state_next = ST_IDLE;
                    end else begin
                        rd_en      = 1'b1;
                        state_next = ST_DUMP_LD;
                    end
                end
            end
            ST_DUMP_LD: begin
                out_load = 1'b1;
                if (dump_last) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_DUMP_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        len_reg <= len_next;
        tag_reg <= tag_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    tkl_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .result   (out_result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMPW'(count_reg) <= MAX_EXT)
        else $error("entry count beyond store depth");

    a_write_in_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_INS_RD || state_reg == ST_INS_CHK))
        else $error("memory write outside insert");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("output register overwritten");

    a_dump_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && in_cmd == CMD_DUMP) |=> !s_tready)
        else $error("input taken during dump");

    a_no_read_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write of the same entry in one cycle");

endmodule

`default_nettype wire

// ===== rtl/core/tkl_out_stage.sv =====
`default_nettype none

module tkl_out_stage
    import tkl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire result_t     result,
    output logic             free,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // entry_length, entry_tag
    output logic             m_tuser,   // entry_valid
    output logic             m_tlast
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, data_reg.tag, data_reg.len};
    assign m_tuser  = data_reg.valid;
    assign m_tlast  = data_reg.last;

endmodule

`default_nettype wire

// ===== tb/top_k_by_length_tracker_unit_tb.sv =====
`timescale 1ns / 1ps

module top_k_by_length_tracker_unit_tb;
    import tkl_pkg::*;

    localparam int KEPT_MAX = 16;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int PRINT_LIMIT = 100;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
        bit               typed;
        result_t          want;
    } dir_row_t;

    typedef struct {
        logic [CAP_W-1:0] cap;
        int               send_pct;
        int               stall_pct;
        int               count;
        bit               opening;
        bit               squeeze;
    } phase_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [31:0]      m_tdata;
    logic             m_tuser;
    logic             m_tlast;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data = '0;

    // predicted store contents
    logic [LEN_W-1:0] kept_len [KEPT_MAX];
    logic [TAG_W-1:0] kept_tag [KEPT_MAX];
    int               kept_count = 0;
    logic [CAP_W-1:0] kept_cap = 5'd16;

    result_t expected_entries[$];

    int error_count = 0;
    int items_sent = 0;
    int dumps_sent = 0;
    int entries_seen = 0;
    int caps_written = 0;
    int send_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    dir_row_t directed_rows [21] = '{
        '{CMD_DUMP,   10'd0,    16'h0000, 1'b1, '{1'b0, 10'd0, 16'h0000, 1'b1}},
        '{CMD_INSERT, 10'd0,    16'h0000, 1'b0, '0},
        '{CMD_DUMP,   10'd0,    16'h0000, 1'b1, '{1'b1, 10'd0, 16'h0000, 1'b1}},
        '{CMD_INSERT, 10'd1023, 16'hffff, 1'b0, '0},
        '{CMD_INSERT, 10'd1023, 16'h1234, 1'b0, '0},
        '{CMD_INSERT, 10'd512,  16'haaaa, 1'b0, '0},
        '{CMD_INSERT, 10'd512,  16'h5555, 1'b0, '0},
        '{CMD_INSERT, 10'd1,    16'h0001, 1'b0, '0},
        '{CMD_DUMP,   10'd0,    16'h0000, 1'b0, '0},
        '{CMD_UNUSED, 10'd1023, 16'hffff, 1'b0, '0},
        '{CMD_DUMP,   10'd1023, 16'hffff, 1'b0, '0},
        '{CMD_CLEAR,  10'd0,    16'h0000, 1'b0, '0},
        '{CMD_DUMP,   10'd0,    16'h0000, 1'b1, '{1'b0, 10'd0, 16'h0000, 1'b1}},
        '{CMD_CLEAR,  10'd1023, 16'hffff, 1'b0, '0},
        '{CMD_UNUSED, 10'd0,    16'h0000, 1'b0, '0},
        '{CMD_DUMP,   10'd0,    16'h0000, 1'b1, '{1'b0, 10'd0, 16'h0000, 1'b1}},
        '{CMD_INSERT, 10'd700,  16'h0700, 1'b0, '0},
        '{CMD_INSERT, 10'd700,  16'h0701, 1'b0, '0},
        '{CMD_INSERT, 10'd699,  16'h0699, 1'b0, '0},
        '{CMD_DUMP,   10'd0,    16'h0000, 1'b0, '0},
        '{CMD_CLEAR,  10'd0,    16'h0000, 1'b0, '0}
    };

    phase_t plan [8] = '{
        '{5'd16, 0,  0,  60, 1'b0, 1'b0},
        '{5'd1,  49, 0,  60, 1'b1, 1'b0},
        '{5'd31, 0,  49, 60, 1'b0, 1'b0},
        '{5'd0,  26, 26, 40, 1'b1, 1'b0},
        '{5'd5,  26, 26, 60, 1'b0, 1'b0},
        '{5'd16, 0,  0,  40, 1'b0, 1'b1},
        '{5'd3,  49, 0,  50, 1'b0, 1'b0},
        '{5'd17, 0,  49, 40, 1'b1, 1'b0}
    };

    top_k_by_length_tracker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // command, item_length, item_tag
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // entry_length, entry_tag
        .m_tuser   (m_tuser),   // entry_valid
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // updates the predicted store and queues the entries a dump reports
    function automatic void track_command(input logic [CMD_W-1:0] cmd,
                                          input logic [LEN_W-1:0] len,
                                          input logic [TAG_W-1:0] tag,
                                          input bit keep_results);
        int lim;
        int slot;
        int pos;
        int i;
        result_t r;
        case (cmd)
            CMD_INSERT: begin
                lim = (kept_cap > KEPT_MAX) ? KEPT_MAX : int'(kept_cap);
                if (kept_count < lim) begin
                    slot = kept_count;
                    kept_count++;
                end else if (kept_count > 0 && len > kept_len[kept_count-1]) begin
                    slot = kept_count - 1;
                end else begin
                    return;
                end
                pos = 0;
                while (pos < slot && kept_len[pos] > len)
                    pos++;
                for (i = slot; i > pos; i--) begin
                    kept_len[i] = kept_len[i-1];
                    kept_tag[i] = kept_tag[i-1];
                end
                kept_len[pos] = len;
                kept_tag[pos] = tag;
            end
            CMD_DUMP: begin
                dumps_sent++;
                if (!keep_results)
                    return;
                if (kept_count == 0) begin
                    r = '{valid: 1'b0, len: '0, tag: '0, last: 1'b1};
                    expected_entries.push_back(r);
                end else begin
                    for (i = 0; i < kept_count; i++) begin
                        r = '{valid: 1'b1, len: kept_len[i], tag: kept_tag[i],
                              last: (i == kept_count - 1)};
                        expected_entries.push_back(r);
                    end
                end
            end
            CMD_CLEAR: begin
                kept_count = 0;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] len,
                             input logic [TAG_W-1:0] tag, input bit typed, input result_t want);
        @(negedge aclk);
        while ($urandom_range(99) < send_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {4'b0, tag, len, cmd};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        track_command(cmd, len, tag, !typed);
        if (typed)
            expected_entries.push_back(want);
        items_sent++;
    endtask

    task automatic random_item();
        int roll;
        logic [CMD_W-1:0] cmd;
        logic [LEN_W-1:0] len;
        roll = $urandom_range(99);
        if (roll < 72)
            cmd = CMD_INSERT;
        else if (roll < 89)
            cmd = CMD_DUMP;
        else if (roll < 92)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_UNUSED;
        case ($urandom_range(3))
            0: len = LEN_W'($urandom_range(1023));
            1: len = LEN_W'($urandom_range(15));
            2: len = 10'd1023 - LEN_W'($urandom_range(15));
            default: len = $urandom_range(1) ? 10'd1023 : 10'd0;
        endcase
        send_item(cmd, len, TAG_W'($urandom_range(65535)), 1'b0, '0);
    endtask

    // drop valid and let the block drain before touching the register
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_entries.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = cap;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        kept_cap = cap;
        caps_written++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            entries_seen++;
            if (expected_entries.size() == 0) begin
                report_mismatch("unexpected result transaction, length",
                                int'(m_tdata[9:0]), -1);
            end else begin
                exp_r = expected_entries.pop_front();
                if (m_tuser !== exp_r.valid)
                    report_mismatch("entry_valid", int'(m_tuser), int'(exp_r.valid));
                if (m_tdata[9:0] !== exp_r.len)
                    report_mismatch("entry_length", int'(m_tdata[9:0]), int'(exp_r.len));
                if (m_tdata[25:10] !== exp_r.tag)
                    report_mismatch("entry_tag", int'(m_tdata[25:10]), int'(exp_r.tag));
                if (m_tlast !== exp_r.last)
                    report_mismatch("last_entry", int'(m_tlast), int'(exp_r.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired at %0t", $realtime);
                $display("top_k_by_length_tracker_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        int p;
        int k;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].len, directed_rows[i].tag,
                      directed_rows[i].typed, directed_rows[i].want);

        for (p = 0; p < 8; p++) begin
            settle();
            write_capacity(plan[p].cap);
            send_pct = plan[p].send_pct;
            stall_pct = plan[p].stall_pct;
            if (plan[p].opening) begin
                send_item(CMD_CLEAR, '0, '0, 1'b0, '0);
                send_item(CMD_INSERT, LEN_W'($urandom_range(1023)),
                          TAG_W'($urandom_range(65535)), 1'b0, '0);
                send_item(CMD_DUMP, '0, '0, 1'b0, '0);
            end
            if (plan[p].squeeze) begin
                // receiver holds off while full dumps pile up behind the output
                hold_left = SQUEEZE_CYCLES;
                for (k = 0; k < KEPT_MAX; k++)
                    send_item(CMD_INSERT, LEN_W'($urandom_range(1023)),
                              TAG_W'($urandom_range(65535)), 1'b0, '0);
                for (k = 0; k < 4; k++)
                    send_item(CMD_DUMP, '0, '0, 1'b0, '0);
            end
            for (k = 0; k < plan[p].count; k++)
                random_item();
        end
        settle();

        $display("sent %0d items (%0d dumps) under %0d capacity settings including 0, 1, 17, 31",
                 items_sent, dumps_sent, caps_written);
        $display("checked %0d result transactions, %0d mismatches", entries_seen, error_count);
        if (error_count == 0) begin
            $display("top_k_by_length_tracker_unit verification clean");
        end else begin
            $display("top_k_by_length_tracker_unit verification failed");
        end
        $finish;
    end

endmodule
